@@ hw/rtl/bphm_pkg.sv @@
// ----------------------------------------------------------------------------
// bphm_pkg: shared types and constants of the peak-hold bar level meter
// Payload structs, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bphm_pkg;

  localparam int BAND_COUNT_DEF    = 256;
  localparam int FRACTION_BITS_DEF = 12;

  localparam int BAND_W        = 8;
  localparam int MAG_W         = 24;
  localparam int LEVEL_W       = 22;
  localparam int POS_W         = 5;
  localparam int SCALE_W       = 22;
  localparam int MAX_HEIGHT_W  = 10;
  localparam int COEF_W        = 16;
  localparam int HEIGHT_INT_W  = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [SCALE_W-1:0]      LEVEL_SCALE_RST  = 22'd58645;
  localparam logic [MAX_HEIGHT_W-1:0] MAX_HEIGHT_RST   = 10'd127;
  localparam logic [COEF_W-1:0]       BAR_DECAY_RST    = 16'd5206;
  localparam logic [COEF_W-1:0]       SPEED_GROWTH_RST = 16'd4518;
  localparam logic [COEF_W-1:0]       INIT_SPEED_RST   = 16'd41;
  localparam int                      SPEED_RESET      = 41;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_SCALE  = 3'd0,
    CFG_MAX_HEIGHT   = 3'd1,
    CFG_BAR_DECAY    = 3'd2,
    CFG_SPEED_GROWTH = 3'd3,
    CFG_INIT_SPEED   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [MAG_W-1:0]  magnitude;
  } in_item_t;

  typedef struct packed {
    logic [BAND_W-1:0]  band_out;
    logic [LEVEL_W-1:0] bar_level;
    logic [LEVEL_W-1:0] peak_level;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/bar_peak_hold_meter.sv @@
// A taken request passes registers p1 to p4, then the output register; a stalled
// output freezes the whole pipeline. One request per clock while in_stall is low.
// Per-band state lives in one RAM, read in stage 4 and written in stage 5, with
// forwarding from the output register so the same band may come back to back.
// Reset: synchronous rst_n clears control, then a clearing pass over all BAND_COUNT
// bands (256 by default) loads every band's state while in_stall stays high.
// ----------------------------------------------------------------------------
// bar_peak_hold_meter: peak-hold level meter with bar and peak ballistics
// Log height from magnitude, scale and clamp, then per-band bar, peak and
// fall-speed update in a five-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bar_peak_hold_meter #(
  parameter int BAND_COUNT    = bphm_pkg::BAND_COUNT_DEF,
  parameter int FRACTION_BITS = bphm_pkg::FRACTION_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire bphm_pkg::in_item_t      in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output bphm_pkg::out_item_t          out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [bphm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [bphm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bphm_pkg::*;

  localparam int IW      = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int SW      = HEIGHT_INT_W + FRACTION_BITS;
  localparam int MW      = 3 * SW;
  localparam int LG_W    = POS_W + FRACTION_BITS;
  localparam int PROD_W  = LG_W + SCALE_W;
  localparam int EXT_W   = SW + COEF_W;
  localparam logic [LG_W-1:0] LOG_OFS   = LG_W'(8) << FRACTION_BITS;
  localparam logic [SW-1:0]   STATE_MAX = '1;
  localparam logic [IW-1:0]   LAST_IDX  = IW'(BAND_COUNT - 1);

  // configuration registers
  logic [SCALE_W-1:0]      level_scale_r;
  logic [MAX_HEIGHT_W-1:0] max_height_r;
  logic [COEF_W-1:0]       bar_decay_r;
  logic [COEF_W-1:0]       speed_growth_r;
  logic [COEF_W-1:0]       init_speed_r;

  // clearing pass
  logic          clr_active_r;
  logic [IW-1:0] clr_idx_r;

  // pipeline
  logic              en;
  logic              accept;
  logic              p1_valid_r, p2_valid_r, p3_valid_r, p4_valid_r;
  logic [BAND_W-1:0] p1_band_r, p2_band_r, p3_band_r, p4_band_r;
  logic [MAG_W-1:0]  p1_mag_r;
  logic [POS_W-1:0]  p1_pos_r;
  logic [LG_W-1:0]   p2_lg_r;
  logic [PROD_W-1:0] p3_prod_r;
  logic [SW-1:0]     p4_h_r;
  logic [MW-1:0]     rd_r;

  logic [POS_W-1:0]  pos_nxt;
  logic [MAG_W-1:0]  norm;
  logic [LG_W-1:0]   lg_raw;
  logic [LG_W-1:0]   lg_nxt;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] hs;
  logic [SW-1:0]     limit;
  logic [SW-1:0]     h_nxt;

  // output and forwarding registers
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          fwd_wr_r;
  logic [BAND_W-1:0] fwd_band_r;
  logic [SW-1:0] fwd_bar_r, fwd_peak_r, fwd_sp_r;

  // update stage
  logic          fwd_hit;
  logic          p4_inr;
  logic [SW-1:0] cur_bar, cur_peak, cur_sp;
  logic [EXT_W-1:0] grow_prod;
  logic [EXT_W-1:0] grown;
  logic [SW-1:0] sp_sat;
  logic [SW-1:0] bar_nxt, peak_nxt, sp_nxt;
  logic [SW-1:0] pk_drop;

  // state memory
  logic [MW-1:0] mem [BAND_COUNT];
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en || clr_active_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_scale_r  <= LEVEL_SCALE_RST;
      max_height_r   <= MAX_HEIGHT_RST;
      bar_decay_r    <= BAR_DECAY_RST;
      speed_growth_r <= SPEED_GROWTH_RST;
      init_speed_r   <= INIT_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL_SCALE:  level_scale_r  <= cfg_data[SCALE_W-1:0];
        CFG_MAX_HEIGHT:   max_height_r   <= cfg_data[MAX_HEIGHT_W-1:0];
        CFG_BAR_DECAY:    bar_decay_r    <= cfg_data[COEF_W-1:0];
        CFG_SPEED_GROWTH: speed_growth_r <= cfg_data[COEF_W-1:0];
        CFG_INIT_SPEED:   init_speed_r   <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_IDX) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // stage 1: leading-one position
  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (in_data.magnitude[b]) pos_nxt = POS_W'(b);
    end
  end

  // stage 2: normalize, take the fraction, drop the offset of 8
  always_comb begin
    norm   = p1_mag_r << (POS_W'(MAG_W - 1) - p1_pos_r);
    lg_raw = {p1_pos_r, norm[MAG_W-2 -: FRACTION_BITS]};
    lg_nxt = (lg_raw > LOG_OFS) ? lg_raw - LOG_OFS : '0;
  end

  // stage 3: scale
  assign prod_nxt = PROD_W'(p2_lg_r) * PROD_W'(level_scale_r);

  // stage 4: truncate and clamp
  always_comb begin
    hs    = p3_prod_r >> FRACTION_BITS;
    limit = {max_height_r, {FRACTION_BITS{1'b0}}};
    h_nxt = (hs > PROD_W'(limit)) ? limit : SW'(hs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= accept;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_band_r <= in_data.band;
      p1_mag_r  <= in_data.magnitude;
      p1_pos_r  <= pos_nxt;
      p2_band_r <= p1_band_r;
      p2_lg_r   <= lg_nxt;
      p3_band_r <= p2_band_r;
      p3_prod_r <= prod_nxt;
      p4_band_r <= p3_band_r;
      p4_h_r    <= h_nxt;
    end
  end

  // state memory: read with stage 4, written by stage 5 or the clearing pass
  always_ff @(posedge clk) begin
    if (en) begin
      rd_r <= mem[IW'(p3_band_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // stage 5: ballistics
  always_comb begin
    p4_inr  = int'(p4_band_r) < BAND_COUNT;
    fwd_hit = out_valid_r && fwd_wr_r && (fwd_band_r == p4_band_r);
    if (fwd_hit) begin
      cur_bar  = fwd_bar_r;
      cur_peak = fwd_peak_r;
      cur_sp   = fwd_sp_r;
    end else begin
      cur_bar  = rd_r[MW-1 -: SW];
      cur_peak = rd_r[2*SW-1 -: SW];
      cur_sp   = rd_r[SW-1:0];
    end

    grow_prod = EXT_W'(cur_sp) * EXT_W'(speed_growth_r);
    grown     = grow_prod >> FRACTION_BITS;
    sp_sat    = (grown > EXT_W'(STATE_MAX)) ? STATE_MAX : SW'(grown);

    if (p4_h_r > cur_bar) begin
      bar_nxt = p4_h_r;
    end else if (EXT_W'(cur_bar) > EXT_W'(bar_decay_r)) begin
      bar_nxt = SW'(EXT_W'(cur_bar) - EXT_W'(bar_decay_r));
    end else begin
      bar_nxt = '0;
    end

    pk_drop = (cur_peak > cur_sp) ? cur_peak - cur_sp : '0;
    if (p4_h_r > cur_bar && p4_h_r > cur_peak) begin
      peak_nxt = p4_h_r;
      sp_nxt   = SW'(init_speed_r);
    end else if (cur_peak != '0) begin
      peak_nxt = (pk_drop < bar_nxt) ? bar_nxt : pk_drop;
      sp_nxt   = sp_sat;
    end else begin
      peak_nxt = cur_peak;
      sp_nxt   = cur_sp;
    end
  end

  always_comb begin
    if (clr_active_r) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
      mem_wd = {{SW{1'b0}}, {SW{1'b0}}, SW'(SPEED_RESET)};
    end else begin
      mem_we = en && p4_valid_r && p4_inr;
      mem_wa = IW'(p4_band_r);
      mem_wd = {bar_nxt, peak_nxt, sp_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_wr_r              <= p4_valid_r && p4_inr;
      fwd_band_r            <= p4_band_r;
      fwd_bar_r             <= bar_nxt;
      fwd_peak_r            <= peak_nxt;
      fwd_sp_r              <= sp_nxt;
      out_data_r.band_out   <= p4_band_r;
      out_data_r.bar_level  <= p4_inr ? LEVEL_W'(bar_nxt) : '0;
      out_data_r.peak_level <= p4_inr ? LEVEL_W'(peak_nxt) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_active_r |=> !clr_active_r)
    else $error("clearing pass restarted");

  a_peak_above_bar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fwd_wr_r |-> fwd_bar_r <= fwd_peak_r)
    else $error("peak below bar");

  a_out_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p4_valid_r))
    else $error("result without a request in stage 4");
`endif

endmodule

`default_nettype wire
